// ===== rtl/core/delta_timer_queue_unit_defines.svh =====
// ----------------------------------------------------------------------------
// delta_timer_queue_unit_defines
// assertion macros shared by the timer queue checker
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DTQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// shared constants, operation codes and cell control type of the timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

    // default sizing
    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int ID_BITS_DEF   = 16;

    // width of the payload ports
    localparam int FIELD_W = 16;
    localparam int MODE_W  = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // operation broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic tick;
    } t_dtq_ctrl;

endpackage

// ===== rtl/core/dtq_cell.sv =====
// ----------------------------------------------------------------------------
// dtq_cell
// one slot of the timer chain: absolute remaining time and id of one entry
// ----------------------------------------------------------------------------
module dtq_cell #(
    parameter int TIME_BITS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                  i_clk,
    input  dtq_pkg::t_dtq_ctrl    i_ctrl,
    input  logic [TIME_BITS-1:0]  i_ttl,
    input  logic [ID_BITS-1:0]    i_id,
    input  logic                  i_valid,
    input  logic [TIME_BITS-1:0]  i_head_time,
    input  logic                  i_left_at,
    input  logic [TIME_BITS-1:0]  i_left_time,
    input  logic [ID_BITS-1:0]    i_left_id,
    input  logic [TIME_BITS-1:0]  i_right_time,
    input  logic [ID_BITS-1:0]    i_right_id,
    output logic                  o_at,
    output logic [TIME_BITS-1:0]  o_time,
    output logic [ID_BITS-1:0]    o_id
);
    import dtq_pkg::*;

    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    logic [ID_BITS-1:0]   r_id;
    logic [ID_BITS-1:0]   n_id;

    // this slot is at or past the insertion point (empty slots always are)
    assign o_at   = !i_valid || (i_ttl <= r_time);
    assign o_time = r_time;
    assign o_id   = r_id;

    // next slot contents: shift right on push, left on pop, count down on tick
    always_comb begin
        n_time = r_time;
        n_id   = r_id;
        if (i_ctrl.push) begin
            if (i_left_at) begin
                n_time = i_left_time;
                n_id   = i_left_id;
            end else if (o_at) begin
                n_time = i_ttl;
                n_id   = i_id;
            end
        end else if (i_ctrl.pop) begin
            // the removed head's remaining time is dropped from every entry
            n_time = i_right_time - i_head_time;
            n_id   = i_right_id;
        end else if (i_ctrl.tick) begin
            n_time = r_time - TIME_BITS'(1);
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_id   <= n_id;
    end

endmodule

// ===== rtl/core/delta_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_unit
// sorted timer queue built as a chain of slots holding absolute times
// ----------------------------------------------------------------------------
// Usage:
//   command channel: drive i_mode, i_ttl and i_item_id with start high; the
//   beat is taken at a clock edge where start is high and busy is low.
//   modes are tick, push, pop and clear.
//   result channel: one beat per command, shown on the o_ ports for one
//   cycle while o_done is high, in the cycle right after the command beat.
//   a new command may be given every cycle while busy is low: each slot
//   is a register, shifting toward its neighbor on push or pop,
//   a pop also drops the old head's time from every slot, and a tick lowers
//   every slot's absolute time together if the queue is non-empty and its head unexpired.
//   the status shows the queue after the command: popped id, expired head,
//   empty queue, and a refused push on a full queue.
//   reset empties the queue; busy is high in the first cycle after reset.
//   the receiver cannot stall, so each result must be taken when o_done is
//   high.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit #(
    parameter int DEPTH     = dtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dtq_pkg::MODE_W-1:0]   i_mode,
    input  logic [dtq_pkg::FIELD_W-1:0]  i_ttl,
    input  logic [dtq_pkg::FIELD_W-1:0]  i_item_id,
    output logic                         o_done,
    output logic                         o_pop_valid,
    output logic [dtq_pkg::FIELD_W-1:0]  o_popped_id,
    output logic                         o_head_expired,
    output logic                         o_queue_empty,
    output logic                         o_push_dropped
);
    import dtq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 r_up;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_done;
    logic                 r_pop_valid;
    logic                 r_push_dropped;
    logic [FIELD_W-1:0]   r_popped_id;

    logic                 w_acc;
    logic                 w_full;
    logic                 w_nonempty;
    logic [TIME_BITS-1:0] w_ttl;
    logic [ID_BITS-1:0]   w_id;
    t_dtq_ctrl            w_ctrl;

    logic                 w_at   [DEPTH];
    logic [TIME_BITS-1:0] w_time [DEPTH];
    logic [ID_BITS-1:0]   w_sid  [DEPTH];

    // command beat and queue occupancy
    assign busy       = !r_up;
    assign w_acc      = start && !busy;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_nonempty = (r_count != '0);
    assign w_ttl      = TIME_BITS'(i_ttl);
    assign w_id       = ID_BITS'(i_item_id);

    // decode the operation for the chain
    always_comb begin
        w_ctrl = '0;
        if (w_acc) begin
            unique case (i_mode)
                MODE_TICK:  w_ctrl.tick = w_nonempty && (w_time[0] != '0);
                MODE_PUSH:  w_ctrl.push = !w_full;
                MODE_POP:   w_ctrl.pop  = w_nonempty;
                MODE_CLEAR: w_ctrl      = '0;
                default:    w_ctrl      = '0;
            endcase
        end
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (w_acc && (i_mode == MODE_CLEAR)) begin
            n_count = '0;
        end else if (w_ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // slot chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        logic                 w_left_at;
        logic [TIME_BITS-1:0] w_left_time;
        logic [ID_BITS-1:0]   w_left_id;
        logic [TIME_BITS-1:0] w_right_time;
        logic [ID_BITS-1:0]   w_right_id;

        if (k == 0) begin : g_first
            assign w_left_at   = 1'b0;
            assign w_left_time = '0;
            assign w_left_id   = '0;
        end else begin : g_mid
            assign w_left_at   = w_at[k-1];
            assign w_left_time = w_time[k-1];
            assign w_left_id   = w_sid[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right_time = '0;
            assign w_right_id   = '0;
        end else begin : g_inner
            assign w_right_time = w_time[k+1];
            assign w_right_id   = w_sid[k+1];
        end

        dtq_cell #(
            .TIME_BITS (TIME_BITS),
            .ID_BITS   (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_ttl        (w_ttl),
            .i_id         (w_id),
            .i_valid      (r_count > CNT_W'(k)),
            .i_head_time  (w_time[0]),
            .i_left_at    (w_left_at),
            .i_left_time  (w_left_time),
            .i_left_id    (w_left_id),
            .i_right_time (w_right_time),
            .i_right_id   (w_right_id),
            .o_at         (w_at[k]),
            .o_time       (w_time[k]),
            .o_id         (w_sid[k])
        );
    end

    // control state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up           <= 1'b0;
            r_count        <= '0;
            r_done         <= 1'b0;
            r_pop_valid    <= 1'b0;
            r_push_dropped <= 1'b0;
        end else begin
            r_up           <= 1'b1;
            r_count        <= n_count;
            r_done         <= w_acc;
            r_pop_valid    <= w_ctrl.pop;
            r_push_dropped <= w_acc && (i_mode == MODE_PUSH) && w_full;
        end
    end

    // popped id payload
    always_ff @(posedge i_clk) begin
        r_popped_id <= w_ctrl.pop ? FIELD_W'(w_sid[0]) : '0;
    end

    // result beat: status reflects the queue after the command
    assign o_done         = r_done;
    assign o_pop_valid    = r_pop_valid;
    assign o_popped_id    = r_popped_id;
    assign o_push_dropped = r_push_dropped;
    assign o_queue_empty  = !w_nonempty;
    assign o_head_expired = w_nonempty && (w_time[0] == '0);

endmodule

// ===== rtl/core/dtq_checker.sv =====
// ----------------------------------------------------------------------------
// dtq_checker
// port-level checks of the timer queue, bound to the top level
// ----------------------------------------------------------------------------
`include "delta_timer_queue_unit_defines.svh"

module dtq_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [dtq_pkg::MODE_W-1:0]   i_mode,
    input  logic                         o_done,
    input  logic                         o_pop_valid,
    input  logic                         o_head_expired,
    input  logic                         o_queue_empty,
    input  logic                         o_push_dropped
);
    import dtq_pkg::*;

    // every command beat gives a result beat in the next cycle
    `DTQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_done, "missing result beat")

    // no result beat without a command beat
    `DTQ_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !(start && !busy), !o_done, "spurious result beat")

    // on a result beat, an empty queue has no expired head
    `DTQ_ASSERT_SAME(a_empty_head, i_clk, i_rst_n, o_done && o_queue_empty, !o_head_expired, "expired head on empty queue")

    // pop of a queue known to be non-empty removes an entry
    `DTQ_ASSERT_NEXT(a_pop_nonempty, i_clk, i_rst_n, start && !busy && (i_mode == MODE_POP) && o_done && !o_queue_empty, o_pop_valid, "pop of non-empty queue lost")

    // clear leaves the queue empty and raises neither pop valid nor push dropped
    `DTQ_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, start && !busy && (i_mode == MODE_CLEAR), o_queue_empty && !o_push_dropped && !o_pop_valid, "clear did not empty the queue")

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_mode         (i_mode),
    .o_done         (o_done),
    .o_pop_valid    (o_pop_valid),
    .o_head_expired (o_head_expired),
    .o_queue_empty  (o_queue_empty),
    .o_push_dropped (o_push_dropped)
);
